>>> hdl/snel_pkg.sv
// Shared constants and control types for the sigmoid nearest-entry lookup block.
`default_nettype none

package snel_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_FRAC_SCALE  = 256;
  localparam int DEF_DATA_WIDTH  = 16;

  // Width of the table slot field of a load item.
  localparam int INDEX_W = 6;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Table write broadcast to every cell.
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
  } snel_load_ctl_t;

  // Control part of the search token that walks the cell chain.
  typedef struct packed {
    logic valid;
    logic done;
    logic hit;
  } snel_tok_ctl_t;

endpackage

`default_nettype wire

>>> hdl/snel_cell.sv
// One table entry of the search chain with its distance compare stage.
`default_nettype none

module snel_cell
  import snel_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int CELL_INDEX = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire snel_load_ctl_t               load,
  input  wire logic signed [DATA_WIDTH-1:0] load_x,
  input  wire logic signed [DATA_WIDTH-1:0] load_y,
  input  wire snel_tok_ctl_t                tok_in,
  input  wire logic signed [DATA_WIDTH-1:0] in_sample,
  input  wire logic        [DATA_WIDTH:0]   in_dprev,
  input  wire logic signed [DATA_WIDTH-1:0] in_prev_y,
  input  wire logic signed [DATA_WIDTH-1:0] in_result,
  output snel_tok_ctl_t                     tok_out,
  output logic signed [DATA_WIDTH-1:0]      out_sample,
  output logic        [DATA_WIDTH:0]        out_dprev,
  output logic signed [DATA_WIDTH-1:0]      out_prev_y,
  output logic signed [DATA_WIDTH-1:0]      out_result
);

  logic signed [DATA_WIDTH-1:0] entry_x;
  logic signed [DATA_WIDTH-1:0] entry_y;
  logic signed [DATA_WIDTH:0]   diff;
  logic        [DATA_WIDTH:0]   abs_diff;
  logic                         wr_hit;
  logic                         stop;

  assign wr_hit = load.en &&
                  ({{(32-INDEX_W){1'b0}}, load.index} == 32'(CELL_INDEX));

  // The difference is one bit wider than the data, so it never wraps.
  assign diff = {in_sample[DATA_WIDTH-1], in_sample} - {entry_x[DATA_WIDTH-1], entry_x};
  assign abs_diff = diff[DATA_WIDTH] ? (DATA_WIDTH+1)'(-diff) : diff;
  assign stop = tok_in.valid && !tok_in.done && (abs_diff >= in_dprev);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      entry_x <= load_x;
      entry_y <= load_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.valid <= tok_in.valid;
      tok_out.done  <= tok_in.done | stop;
      tok_out.hit   <= tok_in.hit | stop;
    end
  end

  always_ff @(posedge clk) begin
    out_sample <= in_sample;
    out_dprev  <= abs_diff;
    out_prev_y <= entry_y;
    out_result <= stop ? in_prev_y : in_result;
  end

endmodule

`default_nettype wire

>>> hdl/sigmoid_nearest_entry_lookup_top.sv
// Top level of the sigmoid nearest-entry lookup: intake, cell chain and result register.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall  | cmd, entry_index, entry_x, entry_y, sample
//  out     | output    | out_valid/out_stall| value, from_table
//
// A load item writes its cell at the clock edge that accepts it.
// A lookup item raises out_valid after it passes the intake register, one
// register per table cell as the search token walks the chain, and the result
// register. One item is in the block at a time, so a lookup occupies it until
// its result item is taken, including any output stall.
// Reset clears the token and handshake state; table contents are left as they
// are and must be loaded before use. in_stall stays high from a lookup's
// acceptance until its result item is taken.
`default_nettype none

module sigmoid_nearest_entry_lookup_top
  import snel_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int FRAC_SCALE  = DEF_FRAC_SCALE,
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         cmd,
  input  wire logic [INDEX_W-1:0]           entry_index,
  input  wire logic signed [DATA_WIDTH-1:0] entry_x,
  input  wire logic signed [DATA_WIDTH-1:0] entry_y,
  input  wire logic signed [DATA_WIDTH-1:0] sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      value,
  output logic                              from_table
);

  // Compare width wide enough for the sample and for 4 * FRAC_SCALE, plus a sign.
  localparam int SCALE_W = $clog2(FRAC_SCALE) + 3;
  localparam int CW = ((DATA_WIDTH > SCALE_W) ? DATA_WIDTH : SCALE_W) + 1;
  localparam logic signed [CW-1:0] HI_BOUND = CW'(4 * FRAC_SCALE);
  localparam logic signed [CW-1:0] LO_BOUND = -HI_BOUND;
  // Ends of the open interval in which the table is searched.
  localparam logic signed [CW-1:0] IN_HI = CW'(4 * FRAC_SCALE - 1);
  localparam logic signed [CW-1:0] IN_LO = CW'(1 - 4 * FRAC_SCALE);
  localparam logic signed [DATA_WIDTH-1:0] SAT_HIGH = DATA_WIDTH'(FRAC_SCALE - 1);
  localparam logic signed [DATA_WIDTH-1:0] SAT_LOW  = DATA_WIDTH'(1);

  logic busy;
  logic busy_next;
  logic in_accept;
  logic out_accept;
  logic lookup_accept;

  snel_load_ctl_t load;

  logic signed [CW-1:0] sample_ext;
  logic                 above;
  logic                 below;
  logic                 in_range;

  // Token links between cells; link 0 is the intake register.
  snel_tok_ctl_t                tok_link  [TABLE_DEPTH+1];
  logic signed [DATA_WIDTH-1:0] smp_link  [TABLE_DEPTH+1];
  logic        [DATA_WIDTH:0]   dprev_link[TABLE_DEPTH+1];
  logic signed [DATA_WIDTH-1:0] prevy_link[TABLE_DEPTH+1];
  logic signed [DATA_WIDTH-1:0] res_link  [TABLE_DEPTH+1];
  logic        [TABLE_DEPTH:0]  tok_valid_vec;

  assign in_stall      = busy;
  assign in_accept     = in_valid && !in_stall;
  assign out_accept    = out_valid && !out_stall;
  assign lookup_accept = in_accept && (cmd == CMD_LOOKUP);

  assign load.en    = in_accept && (cmd == CMD_LOAD);
  assign load.index = entry_index;

  always_comb begin
    busy_next = busy;
    if (lookup_accept) begin
      busy_next = 1'b1;
    end else if (out_accept) begin
      busy_next = 1'b0;
    end
  end

  // Range classification happens at intake; a sample outside the open interval
  // enters the chain already finished, carrying its saturated or zero answer.
  assign sample_ext = {{(CW-DATA_WIDTH){sample[DATA_WIDTH-1]}}, sample};
  assign above    = sample_ext > HI_BOUND;
  assign below    = sample_ext < LO_BOUND;
  assign in_range = sample_ext inside {[IN_LO : IN_HI]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      tok_link[0] <= '0;
    end else begin
      busy              <= busy_next;
      tok_link[0].valid <= lookup_accept;
      tok_link[0].done  <= !in_range;
      tok_link[0].hit   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    smp_link[0]   <= sample;
    prevy_link[0] <= '0;
    if (above) begin
      res_link[0] <= SAT_HIGH;
    end else if (below) begin
      res_link[0] <= SAT_LOW;
    end else begin
      res_link[0] <= '0;
    end
  end

  // The first cell sees a previous distance larger than any real one, so it
  // never stops the walk and only seeds the distance for the second cell.
  assign dprev_link[0] = {1'b1, {DATA_WIDTH{1'b0}}};

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    snel_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CELL_INDEX(g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (load),
      .load_x    (entry_x),
      .load_y    (entry_y),
      .tok_in    (tok_link[g]),
      .in_sample (smp_link[g]),
      .in_dprev  (dprev_link[g]),
      .in_prev_y (prevy_link[g]),
      .in_result (res_link[g]),
      .tok_out   (tok_link[g+1]),
      .out_sample(smp_link[g+1]),
      .out_dprev (dprev_link[g+1]),
      .out_prev_y(prevy_link[g+1]),
      .out_result(res_link[g+1])
    );
  end

  for (genvar v = 0; v <= TABLE_DEPTH; v++) begin : g_vld
    assign tok_valid_vec[v] = tok_link[v].valid;
  end

  // Result register. A token that ran off the end without stopping gives zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tok_link[TABLE_DEPTH].valid) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_link[TABLE_DEPTH].valid) begin
      value      <= tok_link[TABLE_DEPTH].done ? res_link[TABLE_DEPTH] : '0;
      from_table <= tok_link[TABLE_DEPTH].hit;
    end
  end

  // A pending result always belongs to the lookup that holds the block busy.
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy)
    else $error("result pending while block is not busy");

  // At most one lookup is in flight, counting the chain and the result register.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    ($countones(tok_valid_vec) + 32'(out_valid)) <= 1)
    else $error("more than one lookup in flight");

  // A token leaving the chain never finds the result register occupied.
  a_tail_free: assert property (@(posedge clk) disable iff (rst)
    tok_link[TABLE_DEPTH].valid |-> (busy && !out_valid))
    else $error("token reached a full result register");

endmodule

`default_nettype wire

>>> tb/sv/sigmoid_lookup_checker.sv
// Checker that tracks the loaded table, predicts every lookup result and compares it.
`timescale 1ns / 1ps

module sigmoid_lookup_checker
  import snel_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int FRAC_SCALE  = DEF_FRAC_SCALE,
  parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         cmd,
  input  logic [INDEX_W-1:0]           entry_index,
  input  logic signed [DATA_WIDTH-1:0] entry_x,
  input  logic signed [DATA_WIDTH-1:0] entry_y,
  input  logic signed [DATA_WIDTH-1:0] sample,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         from_table,
  output int                           mismatches,
  output int                           outstanding
);

  localparam int LOW_BOUND  = -4 * FRAC_SCALE;
  localparam int HIGH_BOUND = 4 * FRAC_SCALE;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         from_table;
  } sigmoid_result_t;

  logic signed [DATA_WIDTH-1:0] entry_abscissa [TABLE_DEPTH];
  logic signed [DATA_WIDTH-1:0] entry_value    [TABLE_DEPTH];
  sigmoid_result_t              pending_results[$];
  int                           err_count = 0;

  assign mismatches = err_count;

  // Nearest-entry walk; distances are kept one bit wider than the data so they never wrap.
  function automatic sigmoid_result_t approximate(input logic signed [DATA_WIDTH-1:0] arg);
    sigmoid_result_t            r;
    logic signed [DATA_WIDTH:0] diff;
    logic [DATA_WIDTH:0]        dist_prev;
    logic [DATA_WIDTH:0]        dist_cur;
    r.value      = '0;
    r.from_table = 1'b0;
    if (arg > LOW_BOUND && arg < HIGH_BOUND) begin
      diff      = arg - entry_abscissa[0];
      dist_prev = (diff < 0) ? -diff : diff;
      for (int i = 1; i < TABLE_DEPTH && !r.from_table; i++) begin
        diff     = arg - entry_abscissa[i];
        dist_cur = (diff < 0) ? -diff : diff;
        if (dist_cur >= dist_prev) begin
          r.value      = entry_value[i-1];
          r.from_table = 1'b1;
        end
        dist_prev = dist_cur;
      end
    end else if (arg > HIGH_BOUND) begin
      r.value = DATA_WIDTH'(FRAC_SCALE - 1);
    end else if (arg < LOW_BOUND) begin
      r.value = DATA_WIDTH'(1);
    end
    return r;
  endfunction

  task automatic report(input string msg);
    if (err_count < 10) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    err_count++;
  endtask

  always @(posedge clk) begin : monitor
    sigmoid_result_t expected_res;
    if (rst) begin
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cmd == CMD_LOAD) begin
          if (entry_index < TABLE_DEPTH) begin
            entry_abscissa[entry_index] = entry_x;
            entry_value[entry_index]    = entry_y;
          end
        end else begin
          pending_results.push_back(approximate(sample));
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result value %0d from_table %0b with no lookup pending",
                           value, from_table));
        end else begin
          expected_res = pending_results.pop_front();
          if (value !== expected_res.value) begin
            report($sformatf("value expected %0d, got %0d", expected_res.value, value));
          end
          if (from_table !== expected_res.from_table) begin
            report($sformatf("from_table expected %0b, got %0b",
                             expected_res.from_table, from_table));
          end
        end
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

>>> tb/sv/tb_sigmoid_nearest_entry_lookup_top.sv
// Testbench top for the sigmoid nearest-entry lookup: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_sigmoid_nearest_entry_lookup_top;
  import snel_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int SCALE = DEF_FRAC_SCALE;
  localparam int DW    = DEF_DATA_WIDTH;
  localparam int HIGH  = 4 * SCALE;

  // Number of random items after the directed part, split over three idling phases.
  localparam int RANDOM_ITEMS = 600;

  // Watchdog limit on the whole run in nanoseconds; it leaves a wide margin.
  localparam longint TIMEOUT_NS = 64'd500_000 * 20;

  // Ways of filling the whole table. A ramp puts the field extremes at both ends, a sorted
  // table gives meaningful nearest-entry walks (ties included), a table entirely below the
  // lookup range makes every walk run off the end, and noise exercises all bit patterns.
  typedef enum int {TAB_RAMP, TAB_SORTED, TAB_BELOW, TAB_NOISE} table_shape_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 cmd = CMD_LOAD;
  logic [INDEX_W-1:0]   entry_index = '0;
  logic signed [DW-1:0] entry_x = '0;
  logic signed [DW-1:0] entry_y = '0;
  logic signed [DW-1:0] sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] value;
  logic                 from_table;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Abscissas as last loaded, kept only to aim lookup samples at table entries.
  logic signed [DW-1:0] shadow_x [DEPTH];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sigmoid_nearest_entry_lookup_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .entry_index(entry_index),
    .entry_x    (entry_x),
    .entry_y    (entry_y),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .from_table (from_table)
  );

  sigmoid_lookup_checker lookup_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .entry_index(entry_index),
    .entry_x    (entry_x),
    .entry_y    (entry_y),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .from_table (from_table),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // The receiver stalls at random, cycle by cycle, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Presents one item and returns right after the edge that accepted it. It is always
  // entered just after a rising edge, and it makes at most one assignment to in_valid
  // per edge, so a back-to-back item simply keeps valid high.
  task automatic drive_item(input logic c, input logic [INDEX_W-1:0] idx,
                            input logic signed [DW-1:0] x, input logic signed [DW-1:0] y,
                            input logic signed [DW-1:0] s);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    entry_index <= idx;
    entry_x     <= x;
    entry_y     <= y;
    sample      <= s;
    do @(posedge clk); while (in_stall);
    if (c == CMD_LOAD) begin
      shadow_x[idx] = x;
    end
    items_sent++;
  endtask

  task automatic lookup(input int s);
    drive_item(CMD_LOOKUP, INDEX_W'($urandom), DW'($urandom), DW'($urandom), DW'(s));
  endtask

  // Rewrites every entry, so no lookup can ever read an entry that was never loaded.
  task automatic load_table(input table_shape_t shape);
    int x;
    int y;
    int run_x;
    run_x = -1100 + int'($urandom_range(0, 200));
    for (int i = 0; i < DEPTH; i++) begin
      case (shape)
        TAB_RAMP: begin
          x = (i == 0) ? -32768 : (i == DEPTH - 1) ? 32767 : -HIGH + i * 32;
          y = (i == 0) ? -32768 : (i == DEPTH - 1) ? 32767 : i * 4;
        end
        TAB_SORTED: begin
          // Steps of zero produce equal distances, which must stop the walk.
          run_x = run_x + ((i == 0) ? 0 : int'($urandom_range(0, 40)));
          x     = run_x;
          y     = int'($urandom);
        end
        TAB_BELOW: begin
          x = -32768 + i * 64 + int'($urandom_range(0, 63));
          y = int'($urandom);
        end
        default: begin
          x = int'($urandom);
          y = int'($urandom);
        end
      endcase
      drive_item(CMD_LOAD, INDEX_W'(i), DW'(x), DW'(y), DW'($urandom));
    end
  endtask

  // Mostly samples inside the table range; the rest are anywhere, around the saturation
  // bounds, or right next to a loaded abscissa.
  function automatic int pick_sample();
    int sel;
    int s;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      s = int'($urandom_range(0, 2 * HIGH - 2)) - (HIGH - 1);
    end else if (sel < 70) begin
      s = int'($urandom);
    end else if (sel < 85) begin
      s = HIGH - 4 + int'($urandom_range(0, 8));
      if ($urandom_range(0, 1) == 1) begin
        s = -s;
      end
    end else begin
      s = int'(shadow_x[$urandom_range(0, DEPTH - 1)]) + int'($urandom_range(0, 8)) - 4;
    end
    return s;
  endfunction

  // Waits with valid low until every lookup result has been taken. The first edge lets
  // the checker count an item accepted at the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int corner_samples [16] = '{-32768, 32767, -HIGH - 1, -HIGH, -HIGH + 1, HIGH - 1,
                                HIGH, HIGH + 1, 0, -1, 1, -736, -720, 960, 1000, 100};
    int base_items;
    int sel;
    send_idle_pct  = 12;
    recv_stall_pct = 62;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The ramp table carries the most negative and most positive abscissa
    // and y at its ends, so distances beyond the 16-bit signed range appear in the walks.
    load_table(TAB_RAMP);
    foreach (corner_samples[k]) begin
      lookup(corner_samples[k]);
    end
    // Duplicate abscissa: entry 10 equals entry 9, so the walk stops on an equal distance.
    drive_item(CMD_LOAD, INDEX_W'(10), DW'(-736), DW'(-12345), DW'(0));
    lookup(-720);
    lookup(-736);
    drive_item(CMD_LOAD, INDEX_W'(10), DW'(-HIGH + 320), DW'(40), DW'(0));
    // Every abscissa below the lookup range: each walk reaches the end without stopping.
    load_table(TAB_BELOW);
    lookup(0);
    lookup(HIGH - 1);
    lookup(-HIGH + 1);

    // Random part in three idling phases: sender light and receiver heavy, then the
    // reverse, then no idling at all.
    base_items = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        // Hold the sender off once until the block has handed back everything.
        drain();
        send_idle_pct  = 62;
        recv_stall_pct = 12;
      end else if (ph == 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      while (items_sent < base_items + (RANDOM_ITEMS * (ph + 1)) / 3) begin
        sel = $urandom_range(0, 999);
        if (sel < 15) begin
          load_table(table_shape_t'($urandom_range(0, 3)));
        end else if (sel < 115) begin
          drive_item(CMD_LOAD, INDEX_W'($urandom), DW'($urandom), DW'($urandom),
                     DW'($urandom));
        end else begin
          lookup(pick_sample());
        end
      end
    end

    // Let the last result come out, then give the block a full lookup latency to show
    // any stray result.
    drain();
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
